FILE: design/oxc_pkg.sv
// ----------------------------------------------------------------------------
// oxc_pkg: shared types and constants for the order crossover block
// Sequencer state encoding and fixed field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package oxc_pkg;

   // width of each cut point field on the request channel
   localparam int CUT_W = 6;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_LOAD,
      ST_CUTS,
      ST_SEG_RD,
      ST_SEG_WR,
      ST_SCAN_INIT,
      ST_SCAN_RD,
      ST_SCAN_MAP,
      ST_SCAN_WR,
      ST_CLR_RD,
      ST_CLR_WR,
      ST_EMIT_RD,
      ST_EMIT_OUT
   } state_type;

endpackage

`default_nettype wire

FILE: design/oxc_ram.sv
// ----------------------------------------------------------------------------
// oxc_ram: generic simple dual-port RAM
// One write port, one read port, registered read data held when not enabled.
// ----------------------------------------------------------------------------
`default_nettype none

module oxc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: design/oxc_step.sv
// ----------------------------------------------------------------------------
// oxc_step: shared index stepper
// Advances a position by one modulo the run length and flags the last slot.
// ----------------------------------------------------------------------------
`default_nettype none

module oxc_step #(
   parameter int IDX_W = 6,
   parameter int CNT_W = 7
) (
   input  wire logic [IDX_W-1:0] idx,
   input  wire logic [CNT_W-1:0] count,
   output logic      [IDX_W-1:0] next_idx,
   output logic                  at_end
);

   logic [CNT_W-1:0] sum;

   always_comb begin
      sum      = CNT_W'(idx) + CNT_W'(1);
      at_end   = (sum == count);
      next_idx = at_end ? '0 : sum[IDX_W-1:0];
   end

endmodule

`default_nettype wire

FILE: design/order_crossover_permutation.sv
// ----------------------------------------------------------------------------
// order_crossover_permutation: OX1 order crossover of two permutations
//
// Request words load one position of both parents per cycle.
// The word with req_tlast set also carries the two cut points and starts the
// run over the n loaded positions (capped at MAX_GENES, extra genes dropped).
// Cuts are clamped to n-1 and swapped if reversed. req_tready is low for the
// whole run. The run orders the cuts, copies the segment genes with a read and
// a write step each, scans parent two from a setup step with a read, map and
// write step per gene (skipped for n = 1), clears the membership entries of
// the segment genes again, and sends the child in position order, rsp_tlast
// on the final word. Each step is paced by the single read port of each store
// and the one shared index stepper.
// After reset the membership map is swept clear, one entry a cycle, over all
// 2^GENE_BITS entries (256 by default) with req_tready low.
// A stalled receiver simply holds the current response word.
// ----------------------------------------------------------------------------
`default_nettype none

module order_crossover_permutation #(
   parameter int MAX_GENES = 64,
   parameter int GENE_BITS = 8
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_tvalid,
   output logic      req_tready,
   // gene_first, gene_second, cut_low, cut_high (low bit up), zero padded
   input  wire logic [((2*GENE_BITS+2*oxc_pkg::CUT_W+7)/8)*8-1:0] req_tdata,
   input  wire logic req_tlast,   // last_gene
   output logic      rsp_tvalid,
   input  wire logic rsp_tready,
   // child_gene, zero padded
   output logic [((GENE_BITS+7)/8)*8-1:0] rsp_tdata,
   output logic rsp_tlast         // last_child
);

   import oxc_pkg::*;

   localparam int IDX_W     = $clog2(MAX_GENES);
   localparam int CNT_W     = $clog2(MAX_GENES + 1);
   localparam int CMP_W     = (CNT_W > CUT_W) ? CNT_W : CUT_W;
   localparam int RSP_W     = ((GENE_BITS + 7) / 8) * 8;
   localparam int GENE_SPAN = 1 << GENE_BITS;

   state_type state_ff, state_in;

   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [CNT_W-1:0]     n_ff, n_in;
   logic [CUT_W-1:0]     cut_lo_ff, cut_lo_in;
   logic [CUT_W-1:0]     cut_hi_ff, cut_hi_in;
   logic [IDX_W-1:0]     lo_ff, lo_in;
   logic [IDX_W-1:0]     hi_ff, hi_in;
   logic [IDX_W-1:0]     i_ff, i_in;
   logic [IDX_W-1:0]     j_ff, j_in;
   logic [IDX_W-1:0]     pos_ff, pos_in;
   logic [IDX_W-1:0]     k_ff, k_in;
   logic                 scan_end_ff, scan_end_in;
   logic [GENE_BITS-1:0] clr_cnt_ff, clr_cnt_in;
   logic [MAX_GENES-1:0] child_vld_ff, child_vld_in;

   logic req_fire;
   logic full;

   // shared stepper
   logic [IDX_W-1:0] step_x;
   logic [IDX_W-1:0] step_next;
   logic             step_end;

   // store ports
   logic                 par_wr_en;
   logic                 p1_rd_en;
   logic                 p2_rd_en;
   logic [GENE_BITS-1:0] p1_q;
   logic [GENE_BITS-1:0] p2_q;
   logic                 child_wr_en;
   logic [IDX_W-1:0]     child_wr_addr;
   logic [GENE_BITS-1:0] child_wr_data;
   logic                 child_rd_en;
   logic [GENE_BITS-1:0] child_q;
   logic                 map_wr_en;
   logic [GENE_BITS-1:0] map_wr_addr;
   logic                 map_wr_data;
   logic                 map_rd_en;
   logic                 map_q;

   // cut clamp
   logic [CMP_W-1:0] nm1_ext;
   logic [CMP_W-1:0] lo_ext;
   logic [CMP_W-1:0] hi_ext;
   logic [CMP_W-1:0] lo_cl;
   logic [CMP_W-1:0] hi_cl;
   logic [IDX_W-1:0] lo_new;
   logic [IDX_W-1:0] hi_new;

   logic [GENE_BITS-1:0] gene_out;

   assign req_fire = req_tvalid & req_tready;
   assign full     = (cnt_ff == CNT_W'(MAX_GENES));

   oxc_step #(.IDX_W(IDX_W), .CNT_W(CNT_W)) u_step (
      .idx      (step_x),
      .count    (n_ff),
      .next_idx (step_next),
      .at_end   (step_end)
   );

   oxc_ram #(.WIDTH(GENE_BITS), .DEPTH(MAX_GENES)) u_first_store (
      .clock   (clock),
      .wr_en   (par_wr_en),
      .wr_addr (cnt_ff[IDX_W-1:0]),
      .wr_data (req_tdata[GENE_BITS-1:0]),
      .rd_en   (p1_rd_en),
      .rd_addr (i_ff),
      .rd_data (p1_q)
   );

   oxc_ram #(.WIDTH(GENE_BITS), .DEPTH(MAX_GENES)) u_second_store (
      .clock   (clock),
      .wr_en   (par_wr_en),
      .wr_addr (cnt_ff[IDX_W-1:0]),
      .wr_data (req_tdata[2*GENE_BITS-1:GENE_BITS]),
      .rd_en   (p2_rd_en),
      .rd_addr (j_ff),
      .rd_data (p2_q)
   );

   oxc_ram #(.WIDTH(GENE_BITS), .DEPTH(MAX_GENES)) u_child_store (
      .clock   (clock),
      .wr_en   (child_wr_en),
      .wr_addr (child_wr_addr),
      .wr_data (child_wr_data),
      .rd_en   (child_rd_en),
      .rd_addr (k_ff),
      .rd_data (child_q)
   );

   oxc_ram #(.WIDTH(1), .DEPTH(GENE_SPAN)) u_member_map (
      .clock   (clock),
      .wr_en   (map_wr_en),
      .wr_addr (map_wr_addr),
      .wr_data (map_wr_data),
      .rd_en   (map_rd_en),
      .rd_addr (p2_q),
      .rd_data (map_q)
   );

   // clamp to n-1, then order the cuts
   always_comb begin
      nm1_ext = CMP_W'(n_ff - CNT_W'(1));
      lo_ext  = CMP_W'(cut_lo_ff);
      hi_ext  = CMP_W'(cut_hi_ff);
      lo_cl   = (lo_ext > nm1_ext) ? nm1_ext : lo_ext;
      hi_cl   = (hi_ext > nm1_ext) ? nm1_ext : hi_ext;
      if (lo_cl > hi_cl) begin
         lo_new = hi_cl[IDX_W-1:0];
         hi_new = lo_cl[IDX_W-1:0];
      end else begin
         lo_new = lo_cl[IDX_W-1:0];
         hi_new = hi_cl[IDX_W-1:0];
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT: begin
            if (clr_cnt_ff == '1) state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (req_fire && req_tlast) state_in = ST_CUTS;
         end
         ST_CUTS:      state_in = ST_SEG_RD;
         ST_SEG_RD:    state_in = ST_SEG_WR;
         ST_SEG_WR: begin
            if (i_ff == hi_ff) begin
               state_in = (n_ff == CNT_W'(1)) ? ST_CLR_RD : ST_SCAN_INIT;
            end else begin
               state_in = ST_SEG_RD;
            end
         end
         ST_SCAN_INIT: state_in = ST_SCAN_RD;
         ST_SCAN_RD:   state_in = ST_SCAN_MAP;
         ST_SCAN_MAP:  state_in = ST_SCAN_WR;
         ST_SCAN_WR:   state_in = scan_end_ff ? ST_CLR_RD : ST_SCAN_RD;
         ST_CLR_RD:    state_in = ST_CLR_WR;
         ST_CLR_WR:    state_in = (i_ff == hi_ff) ? ST_EMIT_RD : ST_CLR_RD;
         ST_EMIT_RD:   state_in = ST_EMIT_OUT;
         ST_EMIT_OUT: begin
            if (rsp_tready) state_in = step_end ? ST_LOAD : ST_EMIT_RD;
         end
         default:      state_in = ST_INIT;
      endcase
   end

   // outputs and store controls
   always_comb begin
      req_tready    = 1'b0;
      rsp_tvalid    = 1'b0;
      step_x        = i_ff;
      par_wr_en     = 1'b0;
      p1_rd_en      = 1'b0;
      p2_rd_en      = 1'b0;
      child_wr_en   = 1'b0;
      child_wr_addr = i_ff;
      child_wr_data = p1_q;
      child_rd_en   = 1'b0;
      map_wr_en     = 1'b0;
      map_wr_addr   = p1_q;
      map_wr_data   = 1'b0;
      map_rd_en     = 1'b0;
      unique case (state_ff)
         ST_INIT: begin
            map_wr_en   = 1'b1;
            map_wr_addr = clr_cnt_ff;
         end
         ST_LOAD: begin
            req_tready = 1'b1;
            par_wr_en  = req_fire & ~full;
         end
         ST_SEG_RD:    p1_rd_en = 1'b1;
         ST_SEG_WR: begin
            child_wr_en = 1'b1;
            map_wr_en   = 1'b1;
            map_wr_data = 1'b1;
         end
         ST_SCAN_INIT: step_x = hi_ff;
         ST_SCAN_RD: begin
            step_x   = j_ff;
            p2_rd_en = 1'b1;
         end
         ST_SCAN_MAP:  map_rd_en = 1'b1;
         ST_SCAN_WR: begin
            step_x        = pos_ff;
            child_wr_en   = ~map_q;
            child_wr_addr = pos_ff;
            child_wr_data = p2_q;
         end
         ST_CLR_RD:    p1_rd_en = 1'b1;
         ST_CLR_WR:    map_wr_en = 1'b1;
         ST_EMIT_RD:   child_rd_en = 1'b1;
         ST_EMIT_OUT: begin
            step_x     = k_ff;
            rsp_tvalid = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // unwritten child slots read as zero
   assign gene_out  = child_vld_ff[k_ff] ? child_q : '0;
   assign rsp_tdata = RSP_W'(gene_out);
   assign rsp_tlast = step_end;

   // datapath registers
   always_comb begin
      cnt_in       = cnt_ff;
      n_in         = n_ff;
      cut_lo_in    = cut_lo_ff;
      cut_hi_in    = cut_hi_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      pos_in       = pos_ff;
      k_in         = k_ff;
      scan_end_in  = scan_end_ff;
      clr_cnt_in   = clr_cnt_ff;
      child_vld_in = child_vld_ff;
      unique case (state_ff)
         ST_INIT: clr_cnt_in = clr_cnt_ff + GENE_BITS'(1);
         ST_LOAD: begin
            if (req_fire) begin
               if (req_tlast) begin
                  n_in      = full ? cnt_ff : cnt_ff + CNT_W'(1);
                  cnt_in    = '0;
                  cut_lo_in = req_tdata[2*GENE_BITS+CUT_W-1:2*GENE_BITS];
                  cut_hi_in = req_tdata[2*GENE_BITS+2*CUT_W-1:2*GENE_BITS+CUT_W];
               end else if (!full) begin
                  cnt_in = cnt_ff + CNT_W'(1);
               end
            end
         end
         ST_CUTS: begin
            lo_in        = lo_new;
            hi_in        = hi_new;
            i_in         = lo_new;
            child_vld_in = '0;
         end
         ST_SEG_WR: begin
            child_vld_in[i_ff] = 1'b1;
            i_in = (i_ff == hi_ff) ? lo_ff : step_next;
         end
         ST_SCAN_INIT: begin
            j_in   = step_next;
            pos_in = step_next;
         end
         ST_SCAN_RD: begin
            j_in        = step_next;
            scan_end_in = (j_ff == hi_ff);
         end
         ST_SCAN_WR: begin
            if (!map_q) begin
               child_vld_in[pos_ff] = 1'b1;
               pos_in = step_next;
            end
         end
         ST_CLR_WR: begin
            i_in = step_next;
            k_in = '0;
         end
         ST_EMIT_OUT: begin
            if (rsp_tready && !step_end) k_in = step_next;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         cnt_ff       <= '0;
         clr_cnt_ff   <= '0;
         child_vld_ff <= '0;
         scan_end_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         clr_cnt_ff   <= clr_cnt_in;
         child_vld_ff <= child_vld_in;
         scan_end_ff  <= scan_end_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff      <= n_in;
      cut_lo_ff <= cut_lo_in;
      cut_hi_ff <= cut_hi_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      i_ff      <= i_in;
      j_ff      <= j_in;
      pos_ff    <= pos_in;
      k_ff      <= k_in;
   end

endmodule

`default_nettype wire

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// tb: order crossover (OX1) block testbench
// Loads parent pairs word by word and closes each run with cut points.
// A behavioral crossover predicts every child word, and each response word
// is checked against it. The runs are short directed cases (single gene,
// clamped and reversed cuts, repeated genes) plus an overflow run, then
// random runs, mostly valid permutations. Both sides stall at random.
// ----------------------------------------------------------------------------
module tb;
   import oxc_pkg::*;

   localparam int MAX_GENES   = 64;
   localparam int GENE_BITS   = 8;
   localparam int GENE_SPAN   = 1 << GENE_BITS;
   localparam int REQ_W       = ((2*GENE_BITS+2*CUT_W+7)/8)*8;
   localparam int RSP_W       = ((GENE_BITS+7)/8)*8;
   localparam int PAD_W       = REQ_W - 2*GENE_BITS - 2*CUT_W;
   localparam int TOTAL_ITEMS = 375;

   typedef struct packed {
      logic [GENE_BITS-1:0] gene;
      logic                 last;
   } child_word_type;

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata  = '0;
   logic             req_tlast  = 1'b0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic             rsp_tlast;

   // model state
   logic [GENE_BITS-1:0] first_store  [MAX_GENES];
   logic [GENE_BITS-1:0] second_store [MAX_GENES];
   int                   loaded_genes = 0;
   child_word_type       expected_children [$];

   // genes of the run being sent (room for the overflow run)
   logic [GENE_BITS-1:0] run_first  [80];
   logic [GENE_BITS-1:0] run_second [80];

   bit pace_on    = 1'b1;
   bit rsp_stalls = 1'b1;
   int err_count     = 0;
   int items_sent    = 0;
   int runs_sent     = 0;
   int words_checked = 0;

   order_crossover_permutation #(
      .MAX_GENES(MAX_GENES),
      .GENE_BITS(GENE_BITS)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   initial begin
      #20_000_000;
      $display("[order_crossover_permutation] ERROR");
      $finish;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      err_count++;
      $display("mismatch @%0t: %s got %0d expected %0d", $realtime, what, got, want);
   endtask

   // Loads one position and, on the last word, computes the whole child.
   task automatic predict_offspring(input logic [GENE_BITS-1:0] gf, gs,
                                    input logic [CUT_W-1:0] cl, ch, input logic last);
      int n, lo, hi, pos, i, t;
      logic [GENE_BITS-1:0] g;
      logic [GENE_BITS-1:0] child [MAX_GENES];
      bit seen [GENE_SPAN];
      child_word_type w;
      if (loaded_genes < MAX_GENES) begin
         first_store[loaded_genes]  = gf;
         second_store[loaded_genes] = gs;
         loaded_genes++;
      end
      if (!last) return;
      n = loaded_genes;
      for (i = 0; i < MAX_GENES; i++) child[i] = '0;
      for (i = 0; i < GENE_SPAN; i++) seen[i] = 1'b0;
      if (n <= 1) begin
         child[0] = first_store[0];
      end else begin
         lo = (int'(cl) > n - 1) ? n - 1 : int'(cl);
         hi = (int'(ch) > n - 1) ? n - 1 : int'(ch);
         if (lo > hi) begin
            t  = lo;
            lo = hi;
            hi = t;
         end
         for (i = lo; i <= hi; i++) begin
            child[i] = first_store[i];
            seen[first_store[i]] = 1'b1;
         end
         // scan parent two after the segment, wrapping; fill free slots in turn
         pos = (hi + 1) % n;
         for (i = 0; i < n; i++) begin
            g = second_store[(hi + 1 + i) % n];
            if (!seen[g]) begin
               child[pos] = g;
               pos = (pos + 1) % n;
            end
         end
      end
      for (i = 0; i < n; i++) begin
         w.gene = child[i];
         w.last = (i == n - 1);
         expected_children.push_back(w);
      end
      loaded_genes = 0;
      runs_sent++;
   endtask

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_gene_pair(input logic [GENE_BITS-1:0] gf, gs,
                                 input logic [CUT_W-1:0] cl, ch, input logic last);
      int gap;
      if (pace_on && $urandom_range(0, 99) < 25) begin
         req_tvalid <= 1'b0;
         gap = $urandom_range(1, 4);
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{PAD_W{1'b0}}, ch, cl, gs, gf};
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
      predict_offspring(gf, gs, cl, ch, last);
      @(negedge clock);
   endtask

   // Sends run_first/run_second[0..n-1]; cut fields are noise until the last word.
   task automatic send_run(input int n, input logic [CUT_W-1:0] cl, ch);
      int i;
      for (i = 0; i < n; i++) begin
         if (i == n - 1)
            send_gene_pair(run_first[i], run_second[i], cl, ch, 1'b1);
         else
            send_gene_pair(run_first[i], run_second[i], CUT_W'($urandom_range(0, 63)),
                           CUT_W'($urandom_range(0, 63)), 1'b0);
      end
   endtask

   always @(negedge clock) begin
      if (!rsp_stalls)
         rsp_tready <= 1'b1;
      else
         rsp_tready <= ($urandom_range(0, 99) >= 25);
   end

   always @(posedge clock) begin
      child_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_children.size() == 0) begin
            report_mismatch("unexpected child word", int'(rsp_tdata), -1);
         end else begin
            want = expected_children.pop_front();
            words_checked++;
            if (rsp_tdata[GENE_BITS-1:0] !== want.gene)
               report_mismatch("child_gene", int'(rsp_tdata[GENE_BITS-1:0]), int'(want.gene));
            if (rsp_tlast !== want.last)
               report_mismatch("last_child", int'(rsp_tlast), int'(want.last));
            if ((rsp_tdata >> GENE_BITS) !== '0)
               report_mismatch("tdata padding", int'(rsp_tdata), 0);
         end
      end
   end

   task automatic test_single_gene;
      run_first[0]  = 8'd255;
      run_second[0] = 8'd0;
      send_run(1, 6'd63, 6'd0);
      run_first[0]  = 8'd0;
      run_second[0] = 8'd255;
      send_run(1, 6'd0, 6'd63);
   endtask

   task automatic test_cut_edges;
      int i;
      // both cuts far past n-1
      run_first[0]  = 8'd0;
      run_first[1]  = 8'd255;
      run_second[0] = 8'd255;
      run_second[1] = 8'd0;
      send_run(2, 6'd63, 6'd63);
      // reversed cuts
      for (i = 0; i < 5; i++) run_first[i] = GENE_BITS'(i * 60);
      for (i = 0; i < 5; i++) run_second[i] = run_first[(i * 2) % 5];
      send_run(5, 6'd4, 6'd1);
      // segment covers the whole child
      for (i = 0; i < 6; i++) begin
         run_first[i]  = GENE_BITS'(250 + i);
         run_second[i] = GENE_BITS'(255 - i);
      end
      send_run(6, 6'd0, 6'd63);
   endtask

   task automatic test_non_permutation;
      int i;
      // scan writes wrap over segment slots
      run_first[0] = 8'd3;
      run_first[1] = 8'd3;
      run_first[2] = 8'd7;
      run_first[3] = 8'd9;
      run_first[4] = 8'd9;
      run_first[5] = 8'd0;
      run_second[0] = 8'd1;
      run_second[1] = 8'd1;
      run_second[2] = 8'd2;
      run_second[3] = 8'd2;
      run_second[4] = 8'd5;
      run_second[5] = 8'd5;
      send_run(6, 6'd2, 6'd3);
      for (i = 0; i < 4; i++) begin
         run_first[i]  = 8'd255;
         run_second[i] = 8'd0;
      end
      send_run(4, 6'd1, 6'd1);
   endtask

   task automatic test_overflow;
      int i;
      for (i = 0; i < 70; i++) begin
         run_first[i]  = GENE_BITS'($urandom_range(0, 255));
         run_second[i] = GENE_BITS'($urandom_range(0, 255));
      end
      send_run(70, CUT_W'($urandom_range(0, 63)), CUT_W'($urandom_range(0, 63)));
   endtask

   task automatic test_random_runs;
      int pool [GENE_SPAN];
      int n, i, j, t, kind, quiet_until;
      logic [CUT_W-1:0] cl, ch;
      logic [GENE_BITS-1:0] g;
      quiet_until = items_sent + 60;
      pace_on     = 1'b0;
      rsp_stalls  = 1'b0;
      while (items_sent < TOTAL_ITEMS) begin
         if (items_sent >= quiet_until) begin
            pace_on    = 1'b1;
            rsp_stalls = 1'b1;
         end
         kind = $urandom_range(0, 99);
         if (kind < 75) begin
            // valid permutation pair, distinct genes drawn from the full range
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, MAX_GENES)
                                            : $urandom_range(2, 16);
            for (i = 0; i < GENE_SPAN; i++) pool[i] = i;
            for (i = 0; i < n; i++) begin
               j = $urandom_range(i, GENE_SPAN - 1);
               t = pool[i];
               pool[i] = pool[j];
               pool[j] = t;
               run_first[i]  = GENE_BITS'(pool[i]);
               run_second[i] = GENE_BITS'(pool[i]);
            end
            for (i = n - 1; i > 0; i--) begin
               j = $urandom_range(0, i);
               g = run_second[i];
               run_second[i] = run_second[j];
               run_second[j] = g;
            end
            if ($urandom_range(0, 3) == 0) begin
               cl = CUT_W'($urandom_range(0, 63));
               ch = CUT_W'($urandom_range(0, 63));
            end else begin
               cl = CUT_W'($urandom_range(0, n - 1));
               ch = CUT_W'($urandom_range(0, n - 1));
            end
         end else if (kind < 90) begin
            n = $urandom_range(1, 20);
            for (i = 0; i < n; i++) begin
               run_first[i]  = GENE_BITS'($urandom_range(0, 255));
               run_second[i] = GENE_BITS'($urandom_range(0, 255));
            end
            cl = CUT_W'($urandom_range(0, 63));
            ch = CUT_W'($urandom_range(0, 63));
         end else begin
            // heavy repeats from a tiny alphabet
            n = $urandom_range(1, 8);
            for (i = 0; i < n; i++) begin
               run_first[i]  = GENE_BITS'($urandom_range(0, 3));
               run_second[i] = GENE_BITS'($urandom_range(0, 3));
            end
            cl = CUT_W'($urandom_range(0, n - 1));
            ch = CUT_W'($urandom_range(0, n - 1));
         end
         send_run(n, cl, ch);
      end
   endtask

   initial begin
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_single_gene();
      test_cut_edges();
      test_non_permutation();
      test_overflow();
      test_random_runs();
      req_tvalid <= 1'b0;
      req_tlast  <= 1'b0;
      while (expected_children.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      $display("%0d request words in %0d crossover runs, %0d child words checked",
               items_sent, runs_sent, words_checked);
      $display("runs covered one gene, clamped and swapped cuts, overflow and repeated genes");
      if (err_count == 0)
         $display("[order_crossover_permutation] OK");
      else
         $display("[order_crossover_permutation] ERROR");
      $finish;
   end

endmodule

FILE: sim.f
design/oxc_pkg.sv
design/oxc_ram.sv
design/oxc_step.sv
design/order_crossover_permutation.sv
verif/tb.sv
